>>> src/mfmu_pkg.sv
package mfmu_pkg;

    // grid geometry
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    // field widths
    localparam int COORD_W = 6;
    localparam int SIZE_W  = 7;
    localparam int CNT_W   = 13;
    localparam int NEW_W   = 3;

    // map stores: cells, edges between rows, edges between columns
    localparam int CELL_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int YE_DEPTH   = (MAX_HEIGHT + 1) * MAX_WIDTH;
    localparam int XE_DEPTH   = MAX_HEIGHT * (MAX_WIDTH + 1);
    localparam int CELL_AW    = $clog2(CELL_DEPTH);
    localparam int YE_AW      = $clog2(YE_DEPTH);
    localparam int XE_AW      = $clog2(XE_DEPTH);

    // clearing pass covers the largest store
    localparam int CLR_LEN_YX = (YE_DEPTH > XE_DEPTH) ? YE_DEPTH : XE_DEPTH;
    localparam int CLR_LEN    = (CLR_LEN_YX > CELL_DEPTH) ? CLR_LEN_YX : CELL_DEPTH;
    localparam int CLR_AW     = $clog2(CLR_LEN);

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // neighbour / wall positions around a cell
    localparam logic [1:0] NBR_N = 2'd0;
    localparam logic [1:0] NBR_S = 2'd1;
    localparam logic [1:0] NBR_L = 2'd2;
    localparam logic [1:0] NBR_H = 2'd3;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // input operation codes
    localparam logic [1:0] OP_SCAN  = 2'd0;
    localparam logic [1:0] OP_PLACE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef enum logic [1:0] {
        ST_UNSEEN   = 2'd0,
        ST_EXPLORED = 2'd1,
        ST_FRONTIER = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        KIND_SCAN,
        KIND_PLACE,
        KIND_READ,
        KIND_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        BE_CLEAR,
        BE_IDLE,
        BE_CELL,
        BE_NBR,
        BE_FINISH
    } t_be_state;

    // classified command handed from front to back
    typedef struct packed {
        t_kind                kind;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [3:0]           walls;
        logic [3:0]           nbr_ok;
        logic [CELL_AW-1:0]   cell_addr;
        logic [YE_AW-1:0]     ye_n;
        logic [YE_AW-1:0]     ye_s;
        logic [XE_AW-1:0]     xe_l;
        logic [XE_AW-1:0]     xe_h;
    } t_cmd;

    // one result transaction
    typedef struct packed {
        logic                 coord_err;
        logic                 changed;
        logic [CNT_W-1:0]     total;
        logic [NEW_W-1:0]     promoted;
        logic [3:0]           edges;
        t_status              status;
    } t_result;

endpackage

>>> src/mfmu_front.sv
module mfmu_front
    import mfmu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_op,
    input  logic [15:0]          i_data,     // x, y, wall n, wall s, wall low x, wall high x
    input  logic [SIZE_W-1:0]    i_width,
    input  logic [SIZE_W-1:0]    i_height,
    input  logic                 i_blocked,
    input  logic                 i_q_ready,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic [SIZE_W-1:0]  w_eff;
    logic [SIZE_W-1:0]  h_eff;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [SIZE_W-1:0]  x_ext;
    logic [SIZE_W-1:0]  y_ext;
    logic               in_range;
    logic               r_seen_any;

    // size registers above the grid are taken as the grid size
    assign w_eff = (i_width  > SIZE_W'(MAX_WIDTH))  ? SIZE_W'(MAX_WIDTH)  : i_width;
    assign h_eff = (i_height > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : i_height;

    assign x     = i_data[COORD_W-1:0];
    assign y     = i_data[2*COORD_W-1:COORD_W];
    assign x_ext = SIZE_W'(x);
    assign y_ext = SIZE_W'(y);

    assign in_range = (x_ext < w_eff) && (y_ext < h_eff);

    // accept only while the queue has room and the map is not being cleared
    assign o_ready = i_q_ready && !i_blocked;
    assign o_push  = i_valid && o_ready;

    // classification and address generation
    always_comb begin
        o_cmd        = '0;
        o_cmd.x      = x;
        o_cmd.y      = y;
        o_cmd.walls  = i_data[2*COORD_W +: 4];
        o_cmd.nbr_ok[NBR_N] = (y != '0);
        o_cmd.nbr_ok[NBR_S] = (y_ext + SIZE_W'(1)) < h_eff;
        o_cmd.nbr_ok[NBR_L] = (x != '0);
        o_cmd.nbr_ok[NBR_H] = (x_ext + SIZE_W'(1)) < w_eff;
        o_cmd.cell_addr = CELL_AW'(y) * CELL_AW'(MAX_WIDTH) + CELL_AW'(x);
        o_cmd.ye_n   = YE_AW'(y) * YE_AW'(MAX_WIDTH) + YE_AW'(x);
        o_cmd.ye_s   = (YE_AW'(y) + YE_AW'(1)) * YE_AW'(MAX_WIDTH) + YE_AW'(x);
        o_cmd.xe_l   = XE_AW'(y) * XE_AW'(MAX_WIDTH + 1) + XE_AW'(x);
        o_cmd.xe_h   = XE_AW'(y) * XE_AW'(MAX_WIDTH + 1) + XE_AW'(x) + XE_AW'(1);
        if (!in_range) begin
            o_cmd.kind = KIND_ERROR;
        end else begin
            unique case (i_op)
                OP_SCAN:  o_cmd.kind = KIND_SCAN;
                OP_PLACE: o_cmd.kind = KIND_PLACE;
                OP_READ:  o_cmd.kind = KIND_READ;
                default:  o_cmd.kind = KIND_READ;
            endcase
        end
    end

    // sticky flag: at least one transaction taken since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_any <= 1'b0;
        end else if (o_push) begin
            r_seen_any <= 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_no_push_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_blocked |-> !o_push)
        else $error("front took a transaction while the map was clearing");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_q_ready)
        else $error("front pushed into a full queue");

    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_seen_any) |-> r_seen_any)
        else $error("transaction flag dropped without reset");
`endif

endmodule

>>> src/mfmu_queue.sv
module mfmu_queue
    import mfmu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_cmd    o_data,
    input  logic    i_pop
);

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_fill;

    assign o_ready = (r_fill != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_slot[r_rd];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + (QUEUE_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - (QUEUE_AW+1)'(1);
            end
        end
    end

    // payload slots
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

>>> src/mfmu_back.sv
module mfmu_back
    import mfmu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cmd_valid,
    input  t_cmd     i_cmd,
    output logic     o_cmd_pop,
    output logic     o_clearing,
    output logic     o_res_valid,
    output t_result  o_res,
    input  logic     i_res_ready
);

    // map stores
    t_status             r_mem_status [CELL_DEPTH];
    logic                r_mem_ye     [YE_DEPTH];
    logic                r_mem_xe     [XE_DEPTH];

    // control state
    t_be_state           r_state, n_state;
    logic [CLR_AW-1:0]   r_clr, n_clr;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_res_valid, n_res_valid;

    // per-item working registers
    t_cmd                r_cmd, n_cmd;
    logic [1:0]          r_nbr, n_nbr;
    logic [NEW_W-1:0]    r_promoted, n_promoted;
    logic                r_changed, n_changed;
    t_status             r_status, n_status;
    logic [3:0]          r_edges, n_edges;
    t_result             r_res, n_res;

    // registered read data
    t_status             r_st_rd;
    logic                r_ye_rd_n, r_ye_rd_s, r_xe_rd_l, r_xe_rd_h;

    // memory ports
    logic                st_we;
    logic [CELL_AW-1:0]  st_waddr;
    t_status             st_wdata;
    logic [CELL_AW-1:0]  st_raddr;
    logic [1:0]          rd_k;
    logic                ye_we;
    logic [YE_AW-1:0]    ye_waddr;
    logic                ye_wdata;
    logic                xe_we;
    logic [XE_AW-1:0]    xe_waddr;
    logic                xe_wdata;
    logic                load_res;

    function automatic logic [CNT_W-1:0] cnt_up(input logic [CNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + CNT_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] cnt_dn(input logic [CNT_W-1:0] c);
        return (c == '0) ? c : c - CNT_W'(1);
    endfunction

    // cell address of one of the four neighbours
    function automatic logic [CELL_AW-1:0] nbr_addr(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y,
                                                    input logic [1:0] k);
        logic [COORD_W-1:0] nx;
        logic [COORD_W-1:0] ny;
        nx = x;
        ny = y;
        case (k)
            NBR_N:   ny = y - COORD_W'(1);
            NBR_S:   ny = y + COORD_W'(1);
            NBR_L:   nx = x - COORD_W'(1);
            default: nx = x + COORD_W'(1);
        endcase
        return CELL_AW'(ny) * CELL_AW'(MAX_WIDTH) + CELL_AW'(nx);
    endfunction

    assign o_clearing  = (r_state == BE_CLEAR);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // status read address: the cell on pop, then each neighbour in turn
    assign rd_k     = (r_state == BE_CELL) ? NBR_N : r_nbr + 2'd1;
    assign st_raddr = (r_state == BE_IDLE) ? i_cmd.cell_addr
                                           : nbr_addr(r_cmd.x, r_cmd.y, rd_k);

    // next state and memory writes
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_nbr       = r_nbr;
        n_promoted  = r_promoted;
        n_changed   = r_changed;
        n_status    = r_status;
        n_edges     = r_edges;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_res_ready;
        o_cmd_pop   = 1'b0;
        load_res    = 1'b0;
        st_we       = 1'b0;
        st_waddr    = r_cmd.cell_addr;
        st_wdata    = ST_EXPLORED;
        ye_we       = 1'b0;
        ye_waddr    = r_cmd.ye_n;
        ye_wdata    = r_cmd.walls[NBR_N];
        xe_we       = 1'b0;
        xe_waddr    = r_cmd.xe_l;
        xe_wdata    = r_cmd.walls[NBR_L];

        unique case (r_state)
            // reset sweep: unseen cells, walls everywhere
            BE_CLEAR: begin
                st_we    = {1'b0, r_clr} < (CLR_AW+1)'(CELL_DEPTH);
                st_waddr = r_clr[CELL_AW-1:0];
                st_wdata = ST_UNSEEN;
                ye_we    = {1'b0, r_clr} < (CLR_AW+1)'(YE_DEPTH);
                ye_waddr = r_clr[YE_AW-1:0];
                ye_wdata = 1'b1;
                xe_we    = {1'b0, r_clr} < (CLR_AW+1)'(XE_DEPTH);
                xe_waddr = r_clr[XE_AW-1:0];
                xe_wdata = 1'b1;
                n_clr    = r_clr + CLR_AW'(1);
                if (r_clr == CLR_AW'(CLR_LEN - 1)) begin
                    n_state = BE_IDLE;
                end
            end

            // take the next command; cell status and walls are read now
            BE_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop  = 1'b1;
                    n_cmd      = i_cmd;
                    n_promoted = '0;
                    n_changed  = 1'b0;
                    if (i_cmd.kind == KIND_ERROR) begin
                        n_status = ST_UNSEEN;
                        n_edges  = '0;
                        n_state  = BE_FINISH;
                    end else begin
                        n_state  = BE_CELL;
                    end
                end
            end

            // update the addressed cell
            BE_CELL: begin
                n_status = r_st_rd;
                n_edges  = {r_xe_rd_h, r_xe_rd_l, r_ye_rd_s, r_ye_rd_n};
                n_state  = BE_FINISH;
                case (r_cmd.kind)
                    KIND_SCAN: begin
                        if (r_st_rd != ST_EXPLORED) begin
                            st_we     = 1'b1;
                            st_wdata  = ST_EXPLORED;
                            ye_we     = 1'b1;
                            xe_we     = 1'b1;
                            n_count   = cnt_dn(r_count);
                            n_changed = 1'b1;
                            n_status  = ST_EXPLORED;
                            n_edges   = r_cmd.walls;
                            n_nbr     = NBR_N;
                            n_state   = BE_NBR;
                        end
                    end
                    KIND_PLACE: begin
                        if (r_st_rd != ST_FRONTIER) begin
                            st_we     = 1'b1;
                            st_wdata  = ST_FRONTIER;
                            n_count   = cnt_up(r_count);
                            n_changed = 1'b1;
                            n_status  = ST_FRONTIER;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // one neighbour a cycle; the far walls go out with the first
            BE_NBR: begin
                if (r_nbr == NBR_N) begin
                    ye_we    = 1'b1;
                    ye_waddr = r_cmd.ye_s;
                    ye_wdata = r_cmd.walls[NBR_S];
                    xe_we    = 1'b1;
                    xe_waddr = r_cmd.xe_h;
                    xe_wdata = r_cmd.walls[NBR_H];
                end
                if (r_cmd.nbr_ok[r_nbr] && !r_cmd.walls[r_nbr] && (r_st_rd == ST_UNSEEN)) begin
                    st_we      = 1'b1;
                    st_waddr   = nbr_addr(r_cmd.x, r_cmd.y, r_nbr);
                    st_wdata   = ST_FRONTIER;
                    n_count    = cnt_up(r_count);
                    n_promoted = r_promoted + NEW_W'(1);
                end
                n_nbr = r_nbr + 2'd1;
                if (r_nbr == NBR_H) begin
                    n_state = BE_FINISH;
                end
            end

            // hand the result to the output register once it is free
            BE_FINISH: begin
                if (!r_res_valid || i_res_ready) begin
                    load_res        = 1'b1;
                    n_res.status    = r_status;
                    n_res.edges     = r_edges;
                    n_res.promoted  = r_promoted;
                    n_res.total     = r_count;
                    n_res.changed   = r_changed;
                    n_res.coord_err = (r_cmd.kind == KIND_ERROR);
                    n_res_valid     = 1'b1;
                    n_state         = BE_IDLE;
                end
            end

            default: begin
                n_state = BE_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BE_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_nbr      <= n_nbr;
        r_promoted <= n_promoted;
        r_changed  <= n_changed;
        r_status   <= n_status;
        r_edges    <= n_edges;
        if (load_res) begin
            r_res <= n_res;
        end
    end

    // cell status store
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_mem_status[st_waddr] <= st_wdata;
        end
        r_st_rd <= r_mem_status[st_raddr];
    end

    // edges between rows
    always_ff @(posedge i_clk) begin
        if (ye_we) begin
            r_mem_ye[ye_waddr] <= ye_wdata;
        end
        if (o_cmd_pop) begin
            r_ye_rd_n <= r_mem_ye[i_cmd.ye_n];
            r_ye_rd_s <= r_mem_ye[i_cmd.ye_s];
        end
    end

    // edges between columns
    always_ff @(posedge i_clk) begin
        if (xe_we) begin
            r_mem_xe[xe_waddr] <= xe_wdata;
        end
        if (o_cmd_pop) begin
            r_xe_rd_l <= r_mem_xe[i_cmd.xe_l];
            r_xe_rd_h <= r_mem_xe[i_cmd.xe_h];
        end
    end

`ifndef SYNTHESIS
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == $past(r_count)) ||
        (r_count == CNT_W'($past(r_count) + CNT_W'(1))) ||
        (r_count == CNT_W'($past(r_count) - CNT_W'(1))))
        else $error("frontier count moved by more than one in a cycle");

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BE_CLEAR) |-> !o_cmd_pop)
        else $error("command taken during the clearing pass");

    a_res_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_res_valid) |-> ($past(r_state) == BE_FINISH))
        else $error("result raised outside the finish step");

    a_nbr_not_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == BE_NBR) && st_we) |-> (st_waddr != r_cmd.cell_addr))
        else $error("neighbour update hit the scanned cell");
`endif

endmodule

>>> src/maze_frontier_map_update.sv
// Grid maze map for frontier-based exploration: two-bit status per cell
// (unseen, explored, frontier), wall bits on the edges between rows and
// between columns, and a saturating count of frontier cells. Each input
// transaction (scan, place or read) returns exactly one result transaction.
// After reset the map stores are swept in a clearing pass during which
// s_axis_tready stays low; APB writes are taken throughout. Afterwards a
// scan of an unexplored cell runs the back end through its cell, neighbour
// and finish states, other in-range items through cell and finish, and
// out-of-range items through finish alone. The single read and write port
// of the cell status store visits the cell and then its four neighbours
// one per cycle. A two-entry command queue lets input transactions be
// taken while the back end works and a result waits in the output register.
module maze_frontier_map_update
    import mfmu_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [15:0]   s_axis_tdata,   // x_coord, y_coord, wall_low_y, wall_high_y,
                                          // wall_low_x, wall_high_x
    input  logic [1:0]    s_axis_tuser,   // op
    // result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [23:0]   m_axis_tdata,   // cell_status, edge_north, edge_south, edge_low_x,
                                          // edge_high_x, new_frontier_cells, frontier_total,
                                          // map_changed, zero pad
    output logic          m_axis_tuser,   // coord_error
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;
    logic              cfg_wr;
    logic              reg_sel;

    logic              push;
    t_cmd              front_cmd;
    logic              q_ready;
    logic              q_valid;
    t_cmd              q_head;
    logic              pop;
    logic              clearing;
    t_result           res;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_W'(MAX_WIDTH);
            r_height <= SIZE_W'(MAX_HEIGHT);
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_WIDTH:  r_width  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: r_height <= pwdata[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (reg_sel)
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            default:    prdata = '0;
        endcase
    end

    mfmu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_op      (s_axis_tuser),
        .i_data    (s_axis_tdata),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_blocked (clearing),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_cmd     (front_cmd)
    );

    mfmu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_head),
        .i_pop   (pop)
    );

    mfmu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_head),
        .o_cmd_pop   (pop),
        .o_clearing  (clearing),
        .o_res_valid (m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (m_axis_tready)
    );

    // result packing
    assign m_axis_tdata = {1'b0, res.changed, res.total, res.promoted, res.edges, res.status};
    assign m_axis_tuser = res.coord_err;

endmodule
